>>> hdl/hsvrgb_pkg.sv
// hsvrgb_pkg: request and result types, stage link type and fixed-point helpers
// for the hsv to rgb converter; no dependencies
`default_nettype none

package hsvrgb_pkg;

    localparam int unsigned HueWidth  = 11;
    localparam int unsigned ChanWidth = 8;
    localparam int unsigned ProdWidth = 2 * ChanWidth;
    localparam logic [ChanWidth-1:0] ChanMax = 8'd255;
    localparam logic [ProdWidth-1:0] RoundBias = 16'd127;

    typedef enum logic [2:0] {
        SECTOR_RED_RISE   = 3'd0,
        SECTOR_GREEN_FULL = 3'd1,
        SECTOR_BLUE_RISE  = 3'd2,
        SECTOR_BLUE_FULL  = 3'd3,
        SECTOR_RED_RETURN = 3'd4,
        SECTOR_RED_FULL   = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HueWidth-1:0]  hue;
        logic [ChanWidth-1:0] saturation;
        logic [ChanWidth-1:0] brightness;
    } hsv_req_t;

    typedef struct packed {
        logic [ChanWidth-1:0] red;
        logic [ChanWidth-1:0] green;
        logic [ChanWidth-1:0] blue;
    } rgb_res_t;

    // front half to back half: scaled saturation terms
    typedef struct packed {
        logic                 valid;
        logic [2:0]           sector;
        logic                 grey;
        logic [ChanWidth-1:0] v;
        logic [ChanWidth-1:0] p;
        logic [ChanWidth-1:0] q_scale;
        logic [ChanWidth-1:0] t_scale;
    } front_link_t;

    // a * b + 127, ready for the divide by 255
    function automatic logic [ProdWidth-1:0] mul_round(input logic [ChanWidth-1:0] a,
                                                       input logic [ChanWidth-1:0] b);
        logic [ProdWidth-1:0] prod;
        prod = {{ChanWidth{1'b0}}, a} * {{ChanWidth{1'b0}}, b};
        return prod + RoundBias;
    endfunction

    // exact x / 255 for x below 65280
    function automatic logic [ChanWidth-1:0] div255(input logic [ProdWidth-1:0] x);
        logic [ProdWidth:0] acc;
        acc = {1'b0, x} + {{(ChanWidth+1){1'b0}}, x[ProdWidth-1:ChanWidth]}
              + {{ProdWidth{1'b0}}, 1'b1};
        return acc[ProdWidth-1:ChanWidth];
    endfunction

endpackage

`default_nettype wire

>>> hdl/hsvrgb_front.sv
// hsvrgb_front: first two pipeline stages, saturation products and their scaling
// depends on hsvrgb_pkg
`default_nettype none

module hsvrgb_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire hsvrgb_pkg::hsv_req_t   in_data,
    output hsvrgb_pkg::front_link_t     link
);

    logic                                a_valid_reg;
    logic [2:0]                          a_sector_reg;
    logic                                a_grey_reg;
    logic [hsvrgb_pkg::ChanWidth-1:0]    a_v_reg;
    logic [hsvrgb_pkg::ProdWidth-1:0]    a_p_prod_reg;
    logic [hsvrgb_pkg::ProdWidth-1:0]    a_sf_prod_reg;
    logic [hsvrgb_pkg::ProdWidth-1:0]    a_st_prod_reg;

    logic [hsvrgb_pkg::ChanWidth-1:0]    frac;
    logic [hsvrgb_pkg::ChanWidth-1:0]    sat;
    logic [hsvrgb_pkg::ProdWidth-1:0]    a_p_prod_next;
    logic [hsvrgb_pkg::ProdWidth-1:0]    a_sf_prod_next;
    logic [hsvrgb_pkg::ProdWidth-1:0]    a_st_prod_next;

    hsvrgb_pkg::front_link_t             b_reg;
    hsvrgb_pkg::front_link_t             b_next;

    assign frac = in_data.hue[hsvrgb_pkg::ChanWidth-1:0];
    assign sat  = in_data.saturation;

    always_comb
    begin
        a_p_prod_next  = hsvrgb_pkg::mul_round(in_data.brightness,
                                               hsvrgb_pkg::ChanMax - sat);
        a_sf_prod_next = hsvrgb_pkg::mul_round(sat, frac);
        a_st_prod_next = hsvrgb_pkg::mul_round(sat, hsvrgb_pkg::ChanMax - frac);
    end

    // stage a: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sector_reg  <= in_data.hue[hsvrgb_pkg::HueWidth-1:hsvrgb_pkg::ChanWidth];
        a_grey_reg    <= (sat == '0);
        a_v_reg       <= in_data.brightness;
        a_p_prod_reg  <= a_p_prod_next;
        a_sf_prod_reg <= a_sf_prod_next;
        a_st_prod_reg <= a_st_prod_next;
    end

    // stage b: divide by 255
    always_comb
    begin
        b_next.valid   = a_valid_reg;
        b_next.sector  = a_sector_reg;
        b_next.grey    = a_grey_reg;
        b_next.v       = a_v_reg;
        b_next.p       = hsvrgb_pkg::div255(a_p_prod_reg);
        b_next.q_scale = hsvrgb_pkg::ChanMax - hsvrgb_pkg::div255(a_sf_prod_reg);
        b_next.t_scale = hsvrgb_pkg::ChanMax - hsvrgb_pkg::div255(a_st_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    assign link = b_reg;

endmodule

`default_nettype wire

>>> hdl/hsvrgb_back.sv
// hsvrgb_back: last two pipeline stages, value products, sector table and grey path
// depends on hsvrgb_pkg
`default_nettype none

module hsvrgb_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire hsvrgb_pkg::front_link_t   link,
    output logic                           out_valid,
    output hsvrgb_pkg::rgb_res_t           out_data
);

    logic                                c_valid_reg;
    logic [2:0]                          c_sector_reg;
    logic                                c_grey_reg;
    logic [hsvrgb_pkg::ChanWidth-1:0]    c_v_reg;
    logic [hsvrgb_pkg::ChanWidth-1:0]    c_p_reg;
    logic [hsvrgb_pkg::ProdWidth-1:0]    c_q_prod_reg;
    logic [hsvrgb_pkg::ProdWidth-1:0]    c_t_prod_reg;

    logic [hsvrgb_pkg::ChanWidth-1:0]    q;
    logic [hsvrgb_pkg::ChanWidth-1:0]    t;
    logic                                d_valid_reg;
    hsvrgb_pkg::rgb_res_t                d_res_reg;
    hsvrgb_pkg::rgb_res_t                d_res_next;

    // stage c: value products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= link.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        c_sector_reg <= link.sector;
        c_grey_reg   <= link.grey;
        c_v_reg      <= link.v;
        c_p_reg      <= link.p;
        c_q_prod_reg <= hsvrgb_pkg::mul_round(link.v, link.q_scale);
        c_t_prod_reg <= hsvrgb_pkg::mul_round(link.v, link.t_scale);
    end

    // stage d: divide and sector table
    always_comb
    begin
        q = hsvrgb_pkg::div255(c_q_prod_reg);
        t = hsvrgb_pkg::div255(c_t_prod_reg);
        if (c_grey_reg)
        begin
            d_res_next = '{red: c_v_reg, green: c_v_reg, blue: c_v_reg};
        end
        else
        begin
            unique case (c_sector_reg)
                hsvrgb_pkg::SECTOR_RED_RISE:
                    d_res_next = '{red: c_v_reg, green: t, blue: c_p_reg};
                hsvrgb_pkg::SECTOR_GREEN_FULL:
                    d_res_next = '{red: q, green: c_v_reg, blue: c_p_reg};
                hsvrgb_pkg::SECTOR_BLUE_RISE:
                    d_res_next = '{red: c_p_reg, green: c_v_reg, blue: t};
                hsvrgb_pkg::SECTOR_BLUE_FULL:
                    d_res_next = '{red: c_p_reg, green: q, blue: c_v_reg};
                hsvrgb_pkg::SECTOR_RED_RETURN:
                    d_res_next = '{red: t, green: c_p_reg, blue: c_v_reg};
                // sector five and the unused codes above it
                default:
                    d_res_next = '{red: c_v_reg, green: c_p_reg, blue: q};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_res_reg <= d_res_next;
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_res_reg;

endmodule

`default_nettype wire

>>> hdl/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: top level of the four-stage hsv to rgb pipeline
// depends on hsvrgb_pkg, hsvrgb_front and hsvrgb_back
//
// a request (hue, saturation, brightness) is taken on every rising edge with
// start high and busy low; busy stays low, so one colour enters per clock
// the hue carries the sector in bits 10..8 and the fraction in bits 7..0;
// sectors six and seven follow sector five
// the rgb result appears on result with done high for one cycle, after the
// registers of stages a, b, c and d, in request order;
// the receiver cannot hold it off
// throughput is one colour per clock, set by the four register stages:
//   a  saturation and value products
//   b  divide by 255 (add and shift)
//   c  value times scaled saturation products
//   d  divide by 255, sector table, grey path
// reset clears the valid bits; requests in flight are dropped and done
// stays low until new requests have passed the pipeline
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire hsvrgb_pkg::hsv_req_t   request,
    output logic                        busy,
    output logic                        done,
    output hsvrgb_pkg::rgb_res_t        result
);

    hsvrgb_pkg::front_link_t  link;
    logic                     accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsvrgb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_data  (request),
        .link     (link)
    );

    hsvrgb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .link      (link),
        .out_valid (done),
        .out_data  (result)
    );

    a_done_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result without matching request");

    a_request_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("request lost in pipeline");

    a_grey_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(request.saturation == '0, 4)
        |-> (result.red == result.green) && (result.green == result.blue)
            && (result.red == $past(request.brightness, 4)))
        else $error("zero saturation did not give grey");

    a_full_channel: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(request.saturation != '0, 4)
        |-> (result.red == $past(request.brightness, 4))
            || (result.green == $past(request.brightness, 4))
            || (result.blue == $past(request.brightness, 4)))
        else $error("no channel carries the value");

endmodule

`default_nettype wire

>>> bench/hsvrgb_checker.sv
// hsvrgb_checker: watches the request and result channels of hsv_to_rgb_converter,
// predicts each rgb result and compares it with what the block gives
// depends on hsvrgb_pkg
module hsvrgb_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  hsvrgb_pkg::hsv_req_t request,
    input  logic                 done,
    input  hsvrgb_pkg::rgb_res_t result,
    output int                   colour_errors,
    output int                   colours_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    hsvrgb_pkg::rgb_res_t expected_rgb[$];

    initial
    begin
        colour_errors = 0;
        colours_pending = 0;
    end

    function automatic logic [7:0] round_scale(input logic [7:0] a, input logic [7:0] b);
        int unsigned x;
        x = (int'(a) * int'(b) + 127) / 255;
        return x[7:0];
    endfunction

    function automatic hsvrgb_pkg::rgb_res_t rgb_of_hsv(input hsvrgb_pkg::hsv_req_t colour);
        logic [7:0] v, s, f, p, q, t;
        hsvrgb_pkg::rgb_res_t rgb;
        v = colour.brightness;
        s = colour.saturation;
        f = colour.hue[7:0];
        p = round_scale(v, 8'd255 - s);
        q = round_scale(v, 8'd255 - round_scale(s, f));
        t = round_scale(v, 8'd255 - round_scale(s, 8'd255 - f));
        if (s == 8'd0)
        begin
            rgb = '{red: v, green: v, blue: v};
        end
        else
        begin
            case (hsvrgb_pkg::sector_t'(colour.hue[10:8]))
                hsvrgb_pkg::SECTOR_RED_RISE:   rgb = '{red: v, green: t, blue: p};
                hsvrgb_pkg::SECTOR_GREEN_FULL: rgb = '{red: q, green: v, blue: p};
                hsvrgb_pkg::SECTOR_BLUE_RISE:  rgb = '{red: p, green: v, blue: t};
                hsvrgb_pkg::SECTOR_BLUE_FULL:  rgb = '{red: p, green: q, blue: v};
                hsvrgb_pkg::SECTOR_RED_RETURN: rgb = '{red: t, green: p, blue: v};
                default:                       rgb = '{red: v, green: p, blue: q};
            endcase
        end
        return rgb;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (colour_errors < 40)
        begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        colour_errors++;
    endtask

    always @(posedge clk)
    begin
        hsvrgb_pkg::rgb_res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rgb.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = expected_rgb.pop_front();
                    if (result.red !== want.red)
                        report_mismatch("red", result.red, want.red);
                    if (result.green !== want.green)
                        report_mismatch("green", result.green, want.green);
                    if (result.blue !== want.blue)
                        report_mismatch("blue", result.blue, want.blue);
                end
            end
            if (start && !busy)
            begin
                expected_rgb.push_back(rgb_of_hsv(request));
            end
        end
        colours_pending <= expected_rgb.size();
    end

endmodule

>>> bench/tb.sv
// tb: drives directed and random colour requests into hsv_to_rgb_converter
// with random idle gaps and gives the verdict
// depends on hsvrgb_pkg, hsv_to_rgb_converter and hsvrgb_checker
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    hsvrgb_pkg::hsv_req_t request;
    logic                 busy;
    logic                 done;
    hsvrgb_pkg::rgb_res_t result;
    int                   colour_errors;
    int                   colours_pending;

    hsv_to_rgb_converter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    hsvrgb_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .done            (done),
        .result          (result),
        .colour_errors   (colour_errors),
        .colours_pending (colours_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_colour(input hsvrgb_pkg::hsv_req_t colour);
        @(negedge clk);
        start <= 1'b1;
        request <= colour;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (colours_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic hsvrgb_pkg::hsv_req_t random_colour();
        hsvrgb_pkg::hsv_req_t colour;
        if ($urandom_range(19) == 0)
            colour.hue = 11'($urandom_range(2047, 1536));
        else
            colour.hue = 11'($urandom_range(1535));
        colour.saturation = random_channel();
        colour.brightness = random_channel();
        return colour;
    endfunction

    task automatic run_phase(input int count, input int idle_pct);
        repeat (count)
        begin
            while ($urandom_range(99) < idle_pct)
                idle_cycles(1);
            send_colour(random_colour());
        end
    endtask

    initial
    begin
        int wait_count;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_cycles(2);

        // grey, black and white
        send_colour('{hue: 11'd300, saturation: 8'd0, brightness: 8'd0});
        send_colour('{hue: 11'd1000, saturation: 8'd0, brightness: 8'd255});
        send_colour('{hue: 11'd77, saturation: 8'd0, brightness: 8'd128});
        send_colour('{hue: 11'd600, saturation: 8'd255, brightness: 8'd0});
        // sectors zero to five at both ends of the fraction, full saturation and value
        for (int sec = 0; sec < 6; sec++)
        begin
            send_colour('{hue: {3'(sec), 8'd0}, saturation: 8'd255, brightness: 8'd255});
            send_colour('{hue: {3'(sec), 8'd255}, saturation: 8'd255, brightness: 8'd255});
        end
        send_colour('{hue: 11'd1535, saturation: 8'd1, brightness: 8'd255});
        send_colour('{hue: 11'd128, saturation: 8'd128, brightness: 8'd200});
        // sectors six and seven
        send_colour('{hue: 11'd1536, saturation: 8'd255, brightness: 8'd255});
        send_colour('{hue: 11'd1791, saturation: 8'd200, brightness: 8'd180});
        send_colour('{hue: 11'd1900, saturation: 8'd90, brightness: 8'd255});
        send_colour('{hue: 11'd2047, saturation: 8'd255, brightness: 8'd255});
        wait_drained();

        run_phase(560, 13);
        wait_drained();
        run_phase(560, 54);
        wait_drained();
        run_phase(560, 0);

        idle_cycles(1);
        wait_count = 0;
        while (colours_pending != 0 && wait_count < 64)
        begin
            @(posedge clk);
            wait_count++;
        end
        repeat (8) @(posedge clk);

        if (colour_errors == 0 && colours_pending == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
